[hw/rtl/dptq_pkg.sv]
// types, constants and codes shared by the deferred priority task queue
package dptq_pkg;

  localparam int QUEUE_DEPTH = 64;
  localparam int LEVELS      = 4;

  localparam int PTR_W       = $clog2(QUEUE_DEPTH);
  localparam int LVL_W       = 2;
  localparam int OCC_W       = 7;
  localparam int CAP_W       = 7;
  localparam int TOT_W       = 9;
  localparam int OVF_W       = 16;
  localparam int HANDLE_W    = 16;
  localparam int TIME_W      = 32;
  localparam int STATUS_W    = 3;
  localparam int ENTRY_W     = HANDLE_W + TIME_W;
  localparam int STORE_DEPTH = LEVELS * QUEUE_DEPTH;
  localparam int ADDR_W      = $clog2(STORE_DEPTH);

  localparam int IN_TDATA_W  = 88;
  localparam int OUT_TDATA_W = 56;
  localparam int PADDR_W     = 3;
  localparam int PDATA_W     = 32;

  localparam logic [CAP_W-1:0]   CAP_RESET = CAP_W'(64);
  localparam logic [PADDR_W-1:0] ADDR_CAP  = PADDR_W'(0);

  localparam logic OP_ENQ = 1'b0;
  localparam logic OP_DEQ = 1'b1;

  localparam logic [STATUS_W-1:0] STAT_ACCEPTED   = 3'd0;
  localparam logic [STATUS_W-1:0] STAT_OVERFLOW   = 3'd1;
  localparam logic [STATUS_W-1:0] STAT_DISPATCHED = 3'd2;
  localparam logic [STATUS_W-1:0] STAT_DEFERRED   = 3'd3;
  localparam logic [STATUS_W-1:0] STAT_EMPTY      = 3'd4;

  typedef struct packed {
    logic                operation;
    logic [HANDLE_W-1:0] task_handle;
    logic [LVL_W-1:0]    level;
    logic [TIME_W-1:0]   release_time;
    logic [TIME_W-1:0]   current_time;
  } item_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [HANDLE_W-1:0] out_handle;
    logic [LVL_W-1:0]    out_level;
    logic [OCC_W-1:0]    level_occupancy;
    logic [TOT_W-1:0]    queued_sum;
    logic [OVF_W-1:0]    level_overflows;
  } res_t;

  typedef struct packed {
    logic [TIME_W-1:0]   release_time;
    logic [HANDLE_W-1:0] task_handle;
  } entry_t;

  function automatic logic [PTR_W-1:0] bump(input logic [PTR_W-1:0] p);
    logic [PTR_W-1:0] r;
    r = (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + PTR_W'(1);
    return r;
  endfunction

endpackage

[hw/rtl/dptq_ram.sv]
// generic single-port-write, single-port-read ram with registered read
module dptq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[hw/rtl/dptq_core.sv]
// queue control: per-level pointers and counters around the task store
module dptq_core (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  dptq_pkg::item_t      in_item,
  input  logic [dptq_pkg::CAP_W-1:0] capacity,
  output logic                 res_valid,
  input  logic                 res_ready,
  output dptq_pkg::res_t       res
);

  import dptq_pkg::*;

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_READ = 1'b1;

  logic                state, state_next;
  logic [PTR_W-1:0]    head [LEVELS];
  logic [PTR_W-1:0]    head_next [LEVELS];
  logic [PTR_W-1:0]    tail [LEVELS];
  logic [PTR_W-1:0]    tail_next [LEVELS];
  logic [OCC_W-1:0]    occ [LEVELS];
  logic [OCC_W-1:0]    occ_next [LEVELS];
  logic [OVF_W-1:0]    ovf [LEVELS];
  logic [OVF_W-1:0]    ovf_next [LEVELS];
  logic [TOT_W-1:0]    total, total_next;
  logic [LVL_W-1:0]    sel_lvl, sel_lvl_next;
  logic [TIME_W-1:0]   now_time, now_time_next;
  logic                res_valid_next;
  res_t                res_next;

  logic                accept;
  logic [LVL_W-1:0]    enq_lvl;
  logic [LVL_W-1:0]    fnd_lvl;
  logic                found;
  logic [LVL_W-1:0]    idx;
  logic [PTR_W-1:0]    cur_head, cur_tail;
  logic [OCC_W-1:0]    cur_occ;
  logic [OVF_W-1:0]    cur_ovf;
  logic [CAP_W-1:0]    cap_eff;
  logic                we;
  logic [ADDR_W-1:0]   waddr, raddr;
  entry_t              wdata, rdata;

  dptq_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (STORE_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  assign accept   = in_valid && in_ready;
  assign in_ready = (state == ST_IDLE) && (!res_valid || res_ready);
  assign enq_lvl  = (32'(in_item.level) >= LEVELS) ? LVL_W'(LEVELS - 1) : in_item.level;
  assign cap_eff  = (capacity > CAP_W'(QUEUE_DEPTH)) ? CAP_W'(QUEUE_DEPTH) : capacity;

  // lowest non-empty level
  always_comb begin
    found   = 1'b0;
    fnd_lvl = '0;
    for (int l = LEVELS - 1; l >= 0; l--) begin
      if (occ[l] != '0) begin
        found   = 1'b1;
        fnd_lvl = LVL_W'(l);
      end
    end
  end

  always_comb begin
    if (state == ST_READ) begin
      idx = sel_lvl;
    end else if (in_item.operation == OP_DEQ) begin
      idx = fnd_lvl;
    end else begin
      idx = enq_lvl;
    end
  end

  assign cur_head = head[idx];
  assign cur_tail = tail[idx];
  assign cur_occ  = occ[idx];
  assign cur_ovf  = ovf[idx];
  assign raddr    = ADDR_W'(idx) * ADDR_W'(QUEUE_DEPTH) + ADDR_W'(cur_head);
  assign waddr    = ADDR_W'(idx) * ADDR_W'(QUEUE_DEPTH) + ADDR_W'(cur_tail);

  always_comb begin
    state_next     = state;
    head_next      = head;
    tail_next      = tail;
    occ_next       = occ;
    ovf_next       = ovf;
    total_next     = total;
    sel_lvl_next   = sel_lvl;
    now_time_next  = now_time;
    res_next       = res;
    res_valid_next = res_valid && !res_ready;
    we             = 1'b0;
    wdata          = rdata;

    if (state == ST_READ) begin
      head_next[idx] = bump(cur_head);
      res_next.out_handle      = rdata.task_handle;
      res_next.out_level       = idx;
      res_next.level_overflows = cur_ovf;
      res_valid_next           = 1'b1;
      state_next               = ST_IDLE;
      if (now_time >= rdata.release_time) begin
        occ_next[idx]            = cur_occ - OCC_W'(1);
        total_next               = total - TOT_W'(1);
        res_next.status          = STAT_DISPATCHED;
        res_next.level_occupancy = cur_occ - OCC_W'(1);
        res_next.queued_sum      = total - TOT_W'(1);
      end else begin
        we                       = 1'b1;
        tail_next[idx]           = bump(cur_tail);
        res_next.status          = STAT_DEFERRED;
        res_next.level_occupancy = cur_occ;
        res_next.queued_sum      = total;
      end
    end else if (accept) begin
      if (in_item.operation == OP_ENQ) begin
        res_valid_next     = 1'b1;
        res_next.out_handle = '0;
        res_next.out_level  = idx;
        if (cur_occ >= cap_eff) begin
          if (cur_ovf != {OVF_W{1'b1}}) begin
            ovf_next[idx] = cur_ovf + OVF_W'(1);
          end
          res_next.status          = STAT_OVERFLOW;
          res_next.level_occupancy = cur_occ;
          res_next.queued_sum      = total;
          res_next.level_overflows = ovf_next[idx];
        end else begin
          we                       = 1'b1;
          wdata.task_handle        = in_item.task_handle;
          wdata.release_time       = in_item.release_time;
          tail_next[idx]           = bump(cur_tail);
          occ_next[idx]            = cur_occ + OCC_W'(1);
          total_next               = total + TOT_W'(1);
          res_next.status          = STAT_ACCEPTED;
          res_next.level_occupancy = cur_occ + OCC_W'(1);
          res_next.queued_sum      = total + TOT_W'(1);
          res_next.level_overflows = cur_ovf;
        end
      end else if (found) begin
        state_next    = ST_READ;
        sel_lvl_next  = idx;
        now_time_next = in_item.current_time;
      end else begin
        res_valid_next = 1'b1;
        res_next       = '0;
        res_next.status = STAT_EMPTY;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      res_valid <= 1'b0;
      total     <= '0;
      for (int l = 0; l < LEVELS; l++) begin
        head[l] <= '0;
        tail[l] <= '0;
        occ[l]  <= '0;
        ovf[l]  <= '0;
      end
    end else begin
      state     <= state_next;
      res_valid <= res_valid_next;
      total     <= total_next;
      head      <= head_next;
      tail      <= tail_next;
      occ       <= occ_next;
      ovf       <= ovf_next;
    end
  end

  always_ff @(posedge clk) begin
    sel_lvl  <= sel_lvl_next;
    now_time <= now_time_next;
    res      <= res_next;
  end

endmodule

[hw/rtl/deferred_priority_task_queue.sv]
// top level: stream ports, capacity register and output register
// Four strict-priority FIFO levels of tasks sharing one task store in a synchronous
// ram. Enqueue words and dequeue words that find every level empty end when taken;
// a dequeue word that finds a task enters a read state: the head entry is read
// from the store as the word is taken, then compared with the current time and,
// when deferred, written back at the level tail. The result word sits in an
// output register, so a new word is taken while the previous result waits.
// After reset the block is ready at once; the store needs no clearing.
module deferred_priority_task_queue (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_tvalid,
  output logic                             s_tready,
  // task_handle, level, release_time, current_time, zero pad
  input  logic [dptq_pkg::IN_TDATA_W-1:0]  s_tdata,
  // operation
  input  logic                             s_tuser,
  output logic                             m_tvalid,
  input  logic                             m_tready,
  // out_handle, out_level, level_occupancy, queued_sum, level_overflows, zero pad
  output logic [dptq_pkg::OUT_TDATA_W-1:0] m_tdata,
  // status
  output logic [dptq_pkg::STATUS_W-1:0]    m_tuser,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [dptq_pkg::PADDR_W-1:0]     paddr,
  input  logic [dptq_pkg::PDATA_W-1:0]     pwdata,
  output logic [dptq_pkg::PDATA_W-1:0]     prdata,
  output logic                             pready
);

  import dptq_pkg::*;

  logic [CAP_W-1:0] capacity;
  logic             cfg_wr;
  item_t            in_item;
  logic             res_valid, res_ready;
  res_t             res;
  res_t             out_res;
  logic             m_tvalid_next;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready && (paddr == ADDR_CAP);
  assign prdata = (paddr == ADDR_CAP) ? PDATA_W'(capacity) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= CAP_RESET;
    end else if (cfg_wr) begin
      capacity <= pwdata[CAP_W-1:0];
    end
  end

  assign in_item.operation    = s_tuser;
  assign in_item.task_handle  = s_tdata[15:0];
  assign in_item.level        = s_tdata[17:16];
  assign in_item.release_time = s_tdata[49:18];
  assign in_item.current_time = s_tdata[81:50];

  dptq_core u_core (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .in_item   (in_item),
    .capacity  (capacity),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

  assign res_ready     = !m_tvalid || m_tready;
  assign m_tvalid_next = res_valid || (m_tvalid && !m_tready);

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else begin
      m_tvalid <= m_tvalid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      out_res <= res;
    end
  end

  assign m_tuser = out_res.status;
  assign m_tdata = {6'b0, out_res.level_overflows, out_res.queued_sum,
                    out_res.level_occupancy, out_res.out_level, out_res.out_handle};

endmodule
